[hw/rtl/tpr_pkg.sv]
// tpr_pkg: shared constants, codes and state types of the tachometer rpm block
// no dependencies; compiled first

package tpr_pkg;

    localparam int TIME_WIDTH_DEF    = 40;
    localparam int RPM_FRAC_BITS_DEF = 8;

    localparam int EPR_W     = 8;
    localparam int TIMEOUT_W = 32;
    localparam int ALPHA_W   = 17;
    localparam int RPM_W     = 32;
    localparam int CFG_W     = 32;

    localparam logic [63:0] RPM_ONE_MINUTE_US = 64'd60000000;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 17'h10000;

    localparam logic [EPR_W-1:0]     EPR_RESET     = 8'd2;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd500000;
    localparam logic [ALPHA_W-1:0]   ALPHA_RESET   = 17'd16384;

    typedef enum logic [1:0] {
        REG_ENABLED,
        REG_EPR,
        REG_TIMEOUT_US,
        REG_EMA_ALPHA
    } tpr_reg_t;

    typedef enum logic {
        CMD_EDGE,
        CMD_UPDATE
    } tpr_cmd_t;

    typedef enum logic {
        STATUS_OK,
        STATUS_DISABLED
    } tpr_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RATE,
        ST_EMA,
        ST_PUT
    } tpr_state_t;

    typedef enum logic [1:0] {
        RS_IDLE,
        RS_MUL,
        RS_DIV
    } tpr_rate_state_t;

    typedef enum logic {
        ES_IDLE,
        ES_RUN
    } tpr_ema_state_t;

endpackage

[hw/rtl/tpr_if.sv]
// tpr_if: valid/ready channels for event items and result items
// depends on tpr_pkg for its widths

interface tpr_in_if #(
    parameter int TIME_WIDTH = tpr_pkg::TIME_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [TIME_WIDTH-1:0] timestamp_us;

    modport source (output valid, output command, output timestamp_us, input ready);
    modport sink   (input valid, input command, input timestamp_us, output ready);
endinterface

interface tpr_out_if;
    logic                     valid;
    logic                     ready;
    logic                     status;
    logic [tpr_pkg::RPM_W-1:0] rpm_filtered;
    logic [tpr_pkg::RPM_W-1:0] rpm_raw;
    logic                     stopped;

    modport source (output valid, output status, output rpm_filtered, output rpm_raw,
                    output stopped, input ready);
    modport sink   (input valid, input status, input rpm_filtered, input rpm_raw,
                    input stopped, output ready);
endinterface

[hw/rtl/tacho_period_rpm_ema_unit.sv]
// tacho_period_rpm_ema_unit: top level, registers, edge bookkeeping, control
// and the result register; uses tpr_rate and tpr_ema, tpr_pkg and tpr_if
// an edge item is handled in ST_IDLE; an update item that is disabled or stopped
// goes straight to ST_PUT, a running one first passes through tpr_rate and tpr_ema
// (8 multiply steps, one divide step per quotient bit, 17 filter steps);
// the next item is taken once the result is registered in a free output register
// reset clears control and tachometer state and loads the register reset values

module tacho_period_rpm_ema_unit #(
    parameter int TIME_WIDTH    = tpr_pkg::TIME_WIDTH_DEF,
    parameter int RPM_FRAC_BITS = tpr_pkg::RPM_FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    tpr_in_if.sink                    events,
    tpr_out_if.source                 results,
    input  logic                      wr_en,
    input  tpr_pkg::tpr_reg_t         wr_index,
    input  logic [tpr_pkg::CFG_W-1:0] wr_data
);
    import tpr_pkg::*;

    tpr_state_t state_reg, state_next;

    // registers
    logic                 enabled_reg;
    logic [EPR_W-1:0]     epr_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [ALPHA_W-1:0]   alpha_reg;

    // tachometer state
    logic [TIME_WIDTH-1:0] last_edge_reg;
    logic [TIME_WIDTH-1:0] period_reg;
    logic                  seen_reg;
    logic                  since_reg;
    logic [RPM_W-1:0]      filt_reg;

    // pending result
    logic             res_status_reg;
    logic [RPM_W-1:0] res_inst_reg;
    logic             res_stop_reg;

    // output register
    logic             out_valid_reg;
    logic             out_status_reg;
    logic [RPM_W-1:0] out_filt_reg;
    logic [RPM_W-1:0] out_inst_reg;
    logic             out_stop_reg;

    logic [TIME_WIDTH-1:0] ts;
    logic [TIME_WIDTH-1:0] age;
    logic                  accept;
    logic                  is_edge;
    logic                  is_update;
    logic                  stop_cond;
    logic [RPM_W-1:0]      half;
    logic                  half_small;
    logic [RPM_W-1:0]      half_val;
    logic                  out_free;
    logic                  rate_start;
    logic                  rate_done;
    logic [RPM_W-1:0]      rate_raw;
    logic                  ema_start;
    logic                  ema_done;
    logic [RPM_W-1:0]      ema_result;

    assign ts         = events.timestamp_us;
    assign accept     = events.valid && (state_reg == ST_IDLE);
    assign is_edge    = accept && (events.command == CMD_EDGE);
    assign is_update  = accept && (events.command == CMD_UPDATE);
    assign age        = ts - last_edge_reg;
    assign stop_cond  = !seen_reg || (age > TIME_WIDTH'(timeout_reg)) || !since_reg;
    assign half       = {1'b0, filt_reg[RPM_W-1:1]};
    assign half_small = {1'b0, filt_reg[RPM_W-1:1], 1'b0} < ((RPM_W + 1)'(1) << RPM_FRAC_BITS);
    assign half_val   = half_small ? '0 : half;
    assign out_free   = !out_valid_reg || results.ready;

    tpr_rate #(
        .TIME_WIDTH    (TIME_WIDTH),
        .RPM_FRAC_BITS (RPM_FRAC_BITS)
    ) u_rate (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (rate_start),
        .epr    (epr_reg),
        .period (period_reg),
        .done   (rate_done),
        .raw    (rate_raw)
    );

    tpr_ema u_ema (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ema_start),
        .alpha  (alpha_reg),
        .sample (rate_raw),
        .filt   (filt_reg),
        .done   (ema_done),
        .result (ema_result)
    );

    always_comb
    begin
        state_next = state_reg;
        rate_start = 1'b0;
        ema_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (is_update)
                begin
                    if (enabled_reg && !stop_cond)
                    begin
                        rate_start = 1'b1;
                        state_next = ST_RATE;
                    end
                    else
                        state_next = ST_PUT;
                end
            end
            ST_RATE:
            begin
                if (rate_done)
                begin
                    ema_start  = 1'b1;
                    state_next = ST_EMA;
                end
            end
            ST_EMA:
            begin
                if (ema_done)
                    state_next = ST_PUT;
            end
            ST_PUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            enabled_reg   <= 1'b0;
            epr_reg       <= EPR_RESET;
            timeout_reg   <= TIMEOUT_RESET;
            alpha_reg     <= ALPHA_RESET;
            last_edge_reg <= '0;
            period_reg    <= '0;
            seen_reg      <= 1'b0;
            since_reg     <= 1'b0;
            filt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (wr_en)
            begin
                unique case (wr_index)
                    REG_ENABLED:    enabled_reg <= wr_data[0];
                    REG_EPR:        epr_reg     <= wr_data[EPR_W-1:0];
                    REG_TIMEOUT_US: timeout_reg <= wr_data[TIMEOUT_W-1:0];
                    REG_EMA_ALPHA:  alpha_reg   <= wr_data[ALPHA_W-1:0];
                    default: ;
                endcase
            end

            if (is_edge && enabled_reg)
            begin
                if (seen_reg)
                    period_reg <= ts - last_edge_reg;
                last_edge_reg <= ts;
                seen_reg      <= 1'b1;
                since_reg     <= 1'b1;
            end

            if (is_update && enabled_reg)
            begin
                since_reg <= 1'b0;
                if (stop_cond)
                    filt_reg <= half_val;
            end

            if (state_reg == ST_EMA && ema_done)
                filt_reg <= ema_result;

            if (state_reg == ST_PUT && out_free)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_update)
        begin
            res_status_reg <= enabled_reg ? STATUS_OK : STATUS_DISABLED;
            res_inst_reg   <= '0;
            res_stop_reg   <= enabled_reg && stop_cond;
        end
        if (state_reg == ST_RATE && rate_done)
            res_inst_reg <= rate_raw;

        if (state_reg == ST_PUT && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_filt_reg   <= (res_status_reg == STATUS_DISABLED) ? '0 : filt_reg;
            out_inst_reg   <= res_inst_reg;
            out_stop_reg   <= res_stop_reg;
        end
    end

    assign events.ready         = state_reg == ST_IDLE;
    assign results.valid        = out_valid_reg;
    assign results.status       = out_status_reg;
    assign results.rpm_filtered = out_filt_reg;
    assign results.rpm_raw      = out_inst_reg;
    assign results.stopped      = out_stop_reg;

endmodule

[hw/rtl/tpr_rate.sv]
// tpr_rate: bit-serial raw rpm unit, shift-add period * epr then
// restoring division of the scaled minute, one quotient bit per cycle
// depends on tpr_pkg

module tpr_rate #(
    parameter int TIME_WIDTH    = tpr_pkg::TIME_WIDTH_DEF,
    parameter int RPM_FRAC_BITS = tpr_pkg::RPM_FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tpr_pkg::EPR_W-1:0]   epr,
    input  logic [TIME_WIDTH-1:0]       period,
    output logic                        done,
    output logic [tpr_pkg::RPM_W-1:0]   raw
);
    import tpr_pkg::*;

    localparam logic [63:0] NUM_VAL = RPM_ONE_MINUTE_US << RPM_FRAC_BITS;
    localparam int NUM_W = $clog2(NUM_VAL + 64'd1);
    localparam int DEN_W = TIME_WIDTH + EPR_W;
    localparam int CMP_W = (DEN_W > NUM_W) ? DEN_W : NUM_W;
    localparam int STEPS = (NUM_W > EPR_W) ? NUM_W : EPR_W;
    localparam int CNT_W = $clog2(STEPS);

    tpr_rate_state_t state_reg, state_next;

    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] mcand_reg;
    logic [EPR_W-1:0] mplier_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-2:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [RPM_W-1:0] raw_reg;
    logic             done_reg;

    logic [NUM_W-1:0] trial;
    logic [CMP_W-1:0] trial_ext;
    logic [CMP_W-1:0] den_ext;
    logic [CMP_W-1:0] diff;
    logic             ge;
    logic [NUM_W-1:0] quo_fin;
    logic             mul_last;
    logic             div_last;

    assign trial     = {rem_reg, num_reg[NUM_W-1]};
    assign trial_ext = CMP_W'(trial);
    assign den_ext   = CMP_W'(den_reg);
    assign ge        = trial_ext >= den_ext;
    assign diff      = trial_ext - den_ext;
    assign quo_fin   = {quo_reg[NUM_W-2:0], ge};
    assign mul_last  = cnt_reg == CNT_W'(EPR_W - 1);
    assign div_last  = cnt_reg == CNT_W'(NUM_W - 1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            RS_IDLE:
            begin
                if (start)
                    state_next = RS_MUL;
            end
            RS_MUL:
            begin
                if (mul_last)
                    state_next = RS_DIV;
            end
            RS_DIV:
            begin
                if (div_last)
                    state_next = RS_IDLE;
            end
            default: state_next = RS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RS_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == RS_DIV) && div_last;
            if (state_reg == RS_IDLE)
                cnt_reg <= '0;
            else if (mul_last && state_reg == RS_MUL)
                cnt_reg <= '0;
            else
                cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            RS_IDLE:
            begin
                if (start)
                begin
                    mcand_reg  <= DEN_W'(period);
                    mplier_reg <= (epr == '0) ? EPR_W'(1) : epr;
                    den_reg    <= '0;
                    num_reg    <= NUM_W'(NUM_VAL);
                    rem_reg    <= '0;
                end
            end
            RS_MUL:
            begin
                if (mplier_reg[0])
                    den_reg <= den_reg + mcand_reg;
                mcand_reg  <= {mcand_reg[DEN_W-2:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[EPR_W-1:1]};
            end
            RS_DIV:
            begin
                num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                rem_reg <= ge ? diff[NUM_W-2:0] : trial[NUM_W-2:0];
                quo_reg <= quo_fin;
                if (div_last)
                begin
                    // zero period gives zero rpm, otherwise saturate
                    if (den_reg == '0)
                        raw_reg <= '0;
                    else if (64'(quo_fin) > 64'(32'hFFFF_FFFF))
                        raw_reg <= '1;
                    else
                        raw_reg <= RPM_W'(quo_fin);
                end
            end
            default: ;
        endcase
    end

    assign done = done_reg;
    assign raw  = raw_reg;

endmodule

[hw/rtl/tpr_ema.sv]
// tpr_ema: bit-serial exponential moving average, alpha and its complement
// scanned one bit per cycle with a right-shifting accumulator, round to nearest
// depends on tpr_pkg

module tpr_ema (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tpr_pkg::ALPHA_W-1:0]   alpha,
    input  logic [tpr_pkg::RPM_W-1:0]     sample,
    input  logic [tpr_pkg::RPM_W-1:0]     filt,
    output logic                          done,
    output logic [tpr_pkg::RPM_W-1:0]     result
);
    import tpr_pkg::*;

    localparam int ACC_W = RPM_W + 1;
    localparam int SUM_W = RPM_W + 2;
    localparam int CNT_W = $clog2(ALPHA_W);
    localparam logic [ALPHA_W:0] HALF_LSB = (ALPHA_W + 1)'(ALPHA_ONE >> 1);

    tpr_ema_state_t state_reg, state_next;

    logic [CNT_W-1:0]   cnt_reg;
    logic [ALPHA_W-1:0] a_reg;
    logic [ALPHA_W-1:0] b_reg;
    logic [RPM_W-1:0]   sample_reg;
    logic [RPM_W-1:0]   filt_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [ALPHA_W-1:0] lo_reg;
    logic [RPM_W-1:0]   result_reg;
    logic               done_reg;

    logic [ALPHA_W-1:0] a_clamp;
    logic [SUM_W-1:0]   sum;
    logic [ACC_W-1:0]   acc_fin;
    logic [ALPHA_W-1:0] lo_fin;
    logic [ALPHA_W:0]   rnd;
    logic [SUM_W-1:0]   total;
    logic               last;

    assign a_clamp = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
    assign sum     = SUM_W'(acc_reg)
                   + (a_reg[0] ? SUM_W'(sample_reg) : '0)
                   + (b_reg[0] ? SUM_W'(filt_reg) : '0);
    assign acc_fin = sum[SUM_W-1:1];
    assign lo_fin  = {sum[0], lo_reg[ALPHA_W-1:1]};
    assign rnd     = (ALPHA_W + 1)'(lo_fin) + HALF_LSB;
    assign total   = {acc_fin, 1'b0} + SUM_W'(rnd[ALPHA_W:ALPHA_W-1]);
    assign last    = cnt_reg == CNT_W'(ALPHA_W - 1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ES_IDLE:
            begin
                if (start)
                    state_next = ES_RUN;
            end
            ES_RUN:
            begin
                if (last)
                    state_next = ES_IDLE;
            end
            default: state_next = ES_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ES_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ES_RUN) && last;
            if (state_reg == ES_RUN)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else
                cnt_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ES_IDLE)
        begin
            if (start)
            begin
                a_reg      <= a_clamp;
                b_reg      <= ALPHA_ONE - a_clamp;
                sample_reg <= sample;
                filt_reg   <= filt;
                acc_reg    <= '0;
                lo_reg     <= '0;
            end
        end
        else
        begin
            a_reg   <= {1'b0, a_reg[ALPHA_W-1:1]};
            b_reg   <= {1'b0, b_reg[ALPHA_W-1:1]};
            acc_reg <= acc_fin;
            lo_reg  <= lo_fin;
            if (last)
                result_reg <= (total[SUM_W-1:RPM_W] != '0) ? '1 : total[RPM_W-1:0];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
